// ===== hw/rtl/octant_line_rasterizer_top_assert.svh =====
// assertion macros for the octant line rasterizer
// expects signals named clock and reset in the module that uses them
`ifndef OCTANT_LINE_RASTERIZER_TOP_ASSERT_SVH
`define OCTANT_LINE_RASTERIZER_TOP_ASSERT_SVH

// same-cycle implication
`define OLR_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define OLR_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/olr_pkg.sv =====
// shared types and constants of the octant line rasterizer
// no dependencies
package olr_pkg;

   localparam int COORD_FRAC_BITS = 8;
   localparam int SLOPE_FRAC_BITS = 16;

   localparam int IN_W       = 21;
   localparam int ZOOM_W     = 16;
   localparam int MARGIN_W   = 13;
   localparam int WIN_W      = 12;
   localparam int COLOR_W    = 32;
   localparam int STRIDE_W   = 16;
   localparam int BPP_W      = 6;
   localparam int OFFSET_W   = 28;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // scaled coordinates, deltas, magnitudes, stepping positions
   localparam int PROD_W  = IN_W + ZOOM_W + 1;
   localparam int COORD_W = PROD_W - COORD_FRAC_BITS;
   localparam int DELTA_W = COORD_W + 1;
   localparam int MAG_W   = DELTA_W;
   localparam int POS_W   = 32;
   localparam int SLOPE_W = SLOPE_FRAC_BITS + 2;

   // magnitude quotient bits below the saturation limit
   localparam int QUOT_W    = SLOPE_W - 1;
   localparam int CNT_W     = 5;
   localparam logic [CNT_W-1:0] SCALE_LAST = CNT_W'(4);
   localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(QUOT_W - 1);

   localparam logic signed [SLOPE_W-1:0] SLOPE_MAX  = {1'b0, {(SLOPE_W-1){1'b1}}};
   localparam logic signed [SLOPE_W-1:0] SLOPE_MIN  = {1'b1, {(SLOPE_W-1){1'b0}}};
   localparam logic signed [SLOPE_W-1:0] SLOPE_HALF = SLOPE_W'(1) << (SLOPE_FRAC_BITS - 1);
   localparam logic signed [SLOPE_W-1:0] SLOPE_ONE  = SLOPE_W'(1) << SLOPE_FRAC_BITS;
   localparam logic signed [POS_W-1:0]   PIX_ONE    = POS_W'(1) << COORD_FRAC_BITS;

   localparam logic [ZOOM_W-1:0]   ZOOM_RST   = ZOOM_W'(256);
   localparam logic [WIN_W-1:0]    WIDTH_RST  = WIN_W'(1920);
   localparam logic [WIN_W-1:0]    HEIGHT_RST = WIN_W'(1080);
   localparam logic [COLOR_W-1:0]  COLOR_RST  = COLOR_W'(32'h00FF_FFFF);
   localparam logic [STRIDE_W-1:0] STRIDE_RST = STRIDE_W'(7680);
   localparam logic [BPP_W-1:0]    BPP_RST    = BPP_W'(32);

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_TICK = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      OCT_SHALLOW_RISE = 2'd0,
      OCT_STEEP_RISE   = 2'd1,
      OCT_STEEP_FALL   = 2'd2,
      OCT_SHALLOW_FALL = 2'd3
   } octant_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ZOOM     = 3'd0,
      CSR_MARGIN_X = 3'd1,
      CSR_MARGIN_Y = 3'd2,
      CSR_WIDTH    = 3'd3,
      CSR_HEIGHT   = 3'd4,
      CSR_COLOR    = 3'd5,
      CSR_STRIDE   = 3'd6,
      CSR_BPP      = 3'd7
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCALE  = 5'b00010,
      ST_SETUP  = 5'b00100,
      ST_DIVIDE = 5'b01000,
      ST_FINISH = 5'b10000
   } olr_state_type;

   typedef struct packed {
      logic load;       // latch endpoints and octant
      logic tick;       // step the active segment
      logic scale_mul;  // multiply next endpoint coordinate by zoom
      logic scale_acc;  // add margin to the last product
      logic acc_y;      // last product was a y coordinate
      logic setup;      // pick axes, form deltas
      logic div_step;   // one quotient bit
      logic div_first;  // first quotient bit
      logic finish;     // write slope, arm segment
   } olr_cmd_type;

   typedef struct packed {
      logic rsp_full;
   } olr_status_type;

endpackage

// ===== hw/rtl/olr_req_if.sv =====
// request channel of the octant line rasterizer: load or tick items
// depends on olr_pkg
interface olr_req_if import olr_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    opcode;
   logic [1:0]              octant;
   logic signed [IN_W-1:0]  start_x;
   logic signed [IN_W-1:0]  start_y;
   logic signed [IN_W-1:0]  end_x;
   logic signed [IN_W-1:0]  end_y;

   modport source (output valid, opcode, octant, start_x, start_y, end_x, end_y,
                   input ready);
   modport sink   (input valid, opcode, octant, start_x, start_y, end_x, end_y,
                   output ready);
endinterface

// ===== hw/rtl/olr_rsp_if.sv =====
// response channel of the octant line rasterizer: one pixel per tick on an active segment
// depends on olr_pkg
interface olr_rsp_if import olr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                pixel_write;
   logic [OFFSET_W-1:0] pixel_offset;
   logic [COLOR_W-1:0]  pixel_color;
   logic                finished;

   modport source (output valid, pixel_write, pixel_offset, pixel_color, finished,
                   input ready);
   modport sink   (input valid, pixel_write, pixel_offset, pixel_color, finished,
                   output ready);
endinterface

// ===== hw/rtl/olr_ctrl.sv =====
// sequencer of the octant line rasterizer: load sequence and tick handshake
// depends on olr_pkg
module olr_ctrl import olr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_opcode,
   input  logic           rsp_ready,
   input  olr_status_type status,
   output logic           req_ready,
   output olr_cmd_type    cmd
);

   olr_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             req_transfer;

   // output slot frees up in the same cycle it is taken
   assign req_ready    = (state_ff == ST_IDLE) && (!status.rsp_full || rsp_ready);
   assign req_transfer = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_transfer) begin
               if (opcode_type'(req_opcode) == OP_LOAD) begin
                  cmd.load = 1'b1;
                  state_in = ST_SCALE;
                  cnt_in   = '0;
               end else begin
                  cmd.tick = 1'b1;
               end
            end
         end
         ST_SCALE: begin
            // each accumulate adds the product registered by the multiply before it, so the two overlap
            cmd.scale_mul = (cnt_ff != SCALE_LAST);
            cmd.scale_acc = (cnt_ff != '0);
            cmd.acc_y     = ~cnt_ff[0];
            if (cnt_ff == SCALE_LAST) begin
               state_in = ST_SETUP;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_DIVIDE;
            cnt_in    = '0;
         end
         ST_DIVIDE: begin
            cmd.div_step  = 1'b1;
            cmd.div_first = (cnt_ff == '0);
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== hw/rtl/olr_datapath.sv =====
// datapath of the octant line rasterizer: registers, scaling, slope divider, stepping
// depends on olr_pkg and octant_line_rasterizer_top_assert.svh
module olr_datapath import olr_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   input  logic [1:0]              req_octant,
   input  logic signed [IN_W-1:0]  req_start_x,
   input  logic signed [IN_W-1:0]  req_start_y,
   input  logic signed [IN_W-1:0]  req_end_x,
   input  logic signed [IN_W-1:0]  req_end_y,
   input  logic                    rsp_ready,
   input  olr_cmd_type             cmd,
   output olr_status_type          status,
   output logic                    rsp_valid,
   output logic                    rsp_pixel_write,
   output logic [OFFSET_W-1:0]     rsp_pixel_offset,
   output logic [COLOR_W-1:0]      rsp_pixel_color,
   output logic                    rsp_finished
);

   function automatic logic seg_going(input octant_type oct,
                                      input logic signed [POS_W-1:0] pos,
                                      input logic signed [POS_W-1:0] pos_end);
      return (oct == OCT_STEEP_FALL) ? (pos >= pos_end) : (pos <= pos_end);
   endfunction

   // configuration
   logic [ZOOM_W-1:0]          zoom_ff;
   logic signed [MARGIN_W-1:0] margin_x_ff, margin_y_ff;
   logic [WIN_W-1:0]           win_w_ff, win_h_ff;
   logic [COLOR_W-1:0]         color_ff;
   logic [STRIDE_W-1:0]        stride_ff;
   logic [BPP_W-1:0]           bpp_ff;

   // load sequence
   logic signed [IN_W-1:0]    coord_ff [4];
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [COORD_W-1:0] scaled_ff [4];
   logic signed [COORD_W-1:0] scaled_in;
   logic signed [MARGIN_W-1:0] margin_sel;
   logic signed [COORD_W-1:0] margin_ext;

   // setup and divide
   logic signed [DELTA_W-1:0] x1, y1, x2, y2, num, den;
   logic signed [DELTA_W-1:0] major_start, minor_start, major_stop;
   logic [MAG_W-1:0]          num_mag, den_mag;
   logic [MAG_W-1:0]          den_mag_ff, rem_ff;
   logic [QUOT_W-1:0]         quot_ff;
   logic                      num_lsb_ff, neg_ff, den_zero_ff, ovf_ff;
   logic [MAG_W:0]            rem_shift;
   logic                      rem_ge;
   logic signed [SLOPE_W-1:0] slope_in;

   // segment state
   octant_type                oct_ff;
   logic signed [POS_W-1:0]   major_pos_ff, minor_pos_ff, major_end_ff;
   logic signed [SLOPE_W-1:0] err_ff, slope_ff;
   logic                      active_ff;

   // tick
   logic                         x_major;
   logic signed [POS_W-1:0]      px, py, win_x_lim, win_y_lim;
   logic                         in_window;
   logic [WIN_W-1:0]             xi, yi;
   logic [WIN_W+STRIDE_W-1:0]    row_off;
   logic [WIN_W+BPP_W-4:0]       col_off;
   logic [OFFSET_W-1:0]          pix_off;
   logic signed [SLOPE_W:0]      err_sum;
   logic signed [SLOPE_W-1:0]    err_sat, err_next;
   logic                         minor_step;
   logic signed [POS_W-1:0]      minor_next, major_next;
   logic                         going_next;
   logic                         emit;
   logic                         rsp_valid_ff;

   // ---------------- configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         zoom_ff     <= ZOOM_RST;
         margin_x_ff <= '0;
         margin_y_ff <= '0;
         win_w_ff    <= WIDTH_RST;
         win_h_ff    <= HEIGHT_RST;
         color_ff    <= COLOR_RST;
         stride_ff   <= STRIDE_RST;
         bpp_ff      <= BPP_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ZOOM:     zoom_ff     <= csr_wdata[ZOOM_W-1:0];
            CSR_MARGIN_X: margin_x_ff <= csr_wdata[MARGIN_W-1:0];
            CSR_MARGIN_Y: margin_y_ff <= csr_wdata[MARGIN_W-1:0];
            CSR_WIDTH:    win_w_ff    <= csr_wdata[WIN_W-1:0];
            CSR_HEIGHT:   win_h_ff    <= csr_wdata[WIN_W-1:0];
            CSR_COLOR:    color_ff    <= csr_wdata[COLOR_W-1:0];
            CSR_STRIDE:   stride_ff   <= csr_wdata[STRIDE_W-1:0];
            CSR_BPP:      bpp_ff      <= csr_wdata[BPP_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- endpoint scaling, one coordinate per cycle
   assign margin_sel = cmd.acc_y ? margin_y_ff : margin_x_ff;
   assign margin_ext = {{(COORD_W-MARGIN_W-COORD_FRAC_BITS){margin_sel[MARGIN_W-1]}},
                        margin_sel, {COORD_FRAC_BITS{1'b0}}};
   // arithmetic shift of the product is floor division by 256
   assign scaled_in  = prod_ff[COORD_FRAC_BITS +: COORD_W] + margin_ext;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         oct_ff      <= octant_type'(req_octant);
         coord_ff[0] <= req_start_x;
         coord_ff[1] <= req_start_y;
         coord_ff[2] <= req_end_x;
         coord_ff[3] <= req_end_y;
      end else if (cmd.scale_mul) begin
         coord_ff[0] <= coord_ff[1];
         coord_ff[1] <= coord_ff[2];
         coord_ff[2] <= coord_ff[3];
         coord_ff[3] <= coord_ff[0];
      end
      if (cmd.scale_mul) begin
         prod_ff <= coord_ff[0] * $signed({1'b0, zoom_ff});
      end
      if (cmd.scale_acc) begin
         scaled_ff[0] <= scaled_ff[1];
         scaled_ff[1] <= scaled_ff[2];
         scaled_ff[2] <= scaled_ff[3];
         scaled_ff[3] <= scaled_in;
      end
   end

   // ---------------- axis selection and deltas
   assign x1 = DELTA_W'(scaled_ff[0]);
   assign y1 = DELTA_W'(scaled_ff[1]);
   assign x2 = DELTA_W'(scaled_ff[2]);
   assign y2 = DELTA_W'(scaled_ff[3]);

   always_comb begin
      case (oct_ff)
         OCT_SHALLOW_RISE: begin
            num = y2 - y1; den = x2 - x1;
            major_start = x1; minor_start = y1; major_stop = x2;
         end
         OCT_STEEP_RISE: begin
            num = x2 - x1; den = y2 - y1;
            major_start = y1; minor_start = x1; major_stop = y2;
         end
         OCT_STEEP_FALL: begin
            num = x2 - x1; den = y1 - y2;
            major_start = y1; minor_start = x1; major_stop = y2;
         end
         default: begin
            num = y1 - y2; den = x2 - x1;
            major_start = x1; minor_start = y1; major_stop = x2;
         end
      endcase
   end

   assign num_mag = num[DELTA_W-1] ? MAG_W'(-num) : MAG_W'(num);
   assign den_mag = den[DELTA_W-1] ? MAG_W'(-den) : MAG_W'(den);

   // ---------------- restoring divider on magnitudes, one quotient bit per cycle
   // remainder starts at num_mag/2, the low bit of num_mag enters on the first step
   assign rem_shift = {rem_ff, cmd.div_first ? num_lsb_ff : 1'b0};
   assign rem_ge    = rem_shift >= {1'b0, den_mag_ff};

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         den_mag_ff   <= den_mag;
         rem_ff       <= num_mag >> 1;
         num_lsb_ff   <= num_mag[0];
         quot_ff      <= '0;
         neg_ff       <= num[DELTA_W-1] ^ den[DELTA_W-1];
         den_zero_ff  <= (den == '0);
         // quotient would reach the saturation limit
         ovf_ff       <= {1'b0, num_mag} >= {den_mag, 1'b0};
      end else if (cmd.div_step) begin
         rem_ff  <= rem_ge ? MAG_W'(rem_shift - {1'b0, den_mag_ff}) : MAG_W'(rem_shift);
         quot_ff <= {quot_ff[QUOT_W-2:0], rem_ge};
      end
   end

   always_comb begin
      if (den_zero_ff) begin
         slope_in = '0;
      end else if (ovf_ff) begin
         slope_in = neg_ff ? SLOPE_MIN : SLOPE_MAX;
      end else if (neg_ff) begin
         slope_in = -$signed({1'b0, quot_ff});
      end else begin
         slope_in = $signed({1'b0, quot_ff});
      end
   end

   // ---------------- tick: emit current point, then step
   assign x_major   = (oct_ff == OCT_SHALLOW_RISE) || (oct_ff == OCT_SHALLOW_FALL);
   assign px        = x_major ? major_pos_ff : minor_pos_ff;
   assign py        = x_major ? minor_pos_ff : major_pos_ff;
   assign win_x_lim = $signed({{(POS_W-WIN_W-COORD_FRAC_BITS){1'b0}}, win_w_ff,
                               {COORD_FRAC_BITS{1'b0}}});
   assign win_y_lim = $signed({{(POS_W-WIN_W-COORD_FRAC_BITS){1'b0}}, win_h_ff,
                               {COORD_FRAC_BITS{1'b0}}});
   assign in_window = !px[POS_W-1] && !py[POS_W-1] && (px <= win_x_lim) && (py <= win_y_lim);

   assign xi      = px[COORD_FRAC_BITS +: WIN_W];
   assign yi      = py[COORD_FRAC_BITS +: WIN_W];
   assign row_off = yi * stride_ff;
   // byte step is bits_per_pixel / 8
   assign col_off = xi * bpp_ff[BPP_W-1:3];
   assign pix_off = OFFSET_W'(row_off) + OFFSET_W'(col_off);

   assign err_sum = {err_ff[SLOPE_W-1], err_ff} + {slope_ff[SLOPE_W-1], slope_ff};
   always_comb begin
      if (err_sum[SLOPE_W] != err_sum[SLOPE_W-1]) begin
         err_sat = err_sum[SLOPE_W] ? SLOPE_MIN : SLOPE_MAX;
      end else begin
         err_sat = err_sum[SLOPE_W-1:0];
      end
   end

   assign minor_step = err_sat >= SLOPE_HALF;
   assign err_next   = minor_step ? err_sat - SLOPE_ONE : err_sat;
   assign minor_next = !minor_step ? minor_pos_ff :
                       (oct_ff == OCT_SHALLOW_FALL) ? minor_pos_ff - PIX_ONE
                                                    : minor_pos_ff + PIX_ONE;
   assign major_next = (oct_ff == OCT_STEEP_FALL) ? major_pos_ff - PIX_ONE
                                                  : major_pos_ff + PIX_ONE;
   assign going_next = seg_going(oct_ff, major_next, major_end_ff);
   assign emit       = cmd.tick && active_ff;

   // ---------------- segment state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (cmd.finish) begin
         active_ff <= seg_going(oct_ff, major_pos_ff, major_end_ff);
      end else if (emit) begin
         active_ff <= going_next;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         major_pos_ff <= POS_W'(major_start);
         minor_pos_ff <= POS_W'(minor_start);
         major_end_ff <= POS_W'(major_stop);
      end else if (emit) begin
         major_pos_ff <= major_next;
         minor_pos_ff <= minor_next;
      end
      if (cmd.finish) begin
         slope_ff <= slope_in;
         err_ff   <= '0;
      end else if (emit) begin
         err_ff <= err_next;
      end
   end

   // ---------------- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_pixel_write  <= in_window;
         rsp_pixel_offset <= in_window ? pix_off : '0;
         rsp_pixel_color  <= in_window ? color_ff : '0;
         rsp_finished     <= !going_next;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign status.rsp_full = rsp_valid_ff;

   `include "octant_line_rasterizer_top_assert.svh"

   `OLR_ASSERT_NOW(a_clip_zero, rsp_valid_ff && !rsp_pixel_write,
                   rsp_pixel_offset == '0 && rsp_pixel_color == '0,
                   "clipped pixel carries nonzero offset or color")
   `OLR_ASSERT_NOW(a_rem_below_div, cmd.div_step && !den_zero_ff && !ovf_ff,
                   rem_ff < den_mag_ff, "divider remainder not below divisor")
   `OLR_ASSERT_NEXT(a_err_cleared, cmd.finish, err_ff == '0,
                    "error term not cleared on segment load")

endmodule

// ===== hw/rtl/octant_line_rasterizer_top.sv =====
// octant line rasterizer: from the transfer of a load until the next item is taken, the block
// runs 4 zoom multiplies plus margin adds, setup, the 17-bit quotient loop and finish
// a tick's pixel, if its segment is active, appears in the output register the cycle after,
// and ticks sustain one per cycle while the result side keeps taking
// synchronous active-high reset: config to defaults, no segment, output empty
// depends on olr_pkg, olr_req_if, olr_rsp_if, olr_ctrl, olr_datapath
module octant_line_rasterizer_top import olr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   olr_req_if.sink               req_if,
   olr_rsp_if.source             rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   olr_cmd_type    cmd;
   olr_status_type status;

   olr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_opcode (req_if.opcode),
      .rsp_ready  (rsp_if.ready),
      .status     (status),
      .req_ready  (req_if.ready),
      .cmd        (cmd)
   );

   olr_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_octant       (req_if.octant),
      .req_start_x      (req_if.start_x),
      .req_start_y      (req_if.start_y),
      .req_end_x        (req_if.end_x),
      .req_end_y        (req_if.end_y),
      .rsp_ready        (rsp_if.ready),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_if.valid),
      .rsp_pixel_write  (rsp_if.pixel_write),
      .rsp_pixel_offset (rsp_if.pixel_offset),
      .rsp_pixel_color  (rsp_if.pixel_color),
      .rsp_finished     (rsp_if.finished)
   );

endmodule

// ===== verif/tb_octant_line_rasterizer_top.sv =====
`timescale 1ns / 100ps
// self-checking testbench for octant_line_rasterizer_top: load and tick stimulus
// with random gaps, a pixel predictor class and per-field checks of every pixel
// depends on olr_pkg, olr_req_if, olr_rsp_if and the rasterizer rtl
module tb_octant_line_rasterizer_top;
   import olr_pkg::*;

   localparam int  SETTLE_CYCLES = 32;
   localparam int  RANDOM_ITEMS  = 1520;
   localparam int  PHASES        = 8;
   localparam int  MAX_REPORTS   = 40;
   localparam longint MAP_HIGH   = (longint'(1) << (IN_W - 1)) - 1;
   localparam longint MAP_LOW    = -MAP_HIGH - 1;

   typedef struct packed {
      opcode_type             opcode;
      octant_type             octant;
      logic signed [IN_W-1:0] start_x;
      logic signed [IN_W-1:0] start_y;
      logic signed [IN_W-1:0] end_x;
      logic signed [IN_W-1:0] end_y;
   } line_cmd_t;

   typedef struct packed {
      logic                write;
      logic [OFFSET_W-1:0] offset;
      logic [COLOR_W-1:0]  color;
      logic                finished;
   } pixel_t;

   // tracks the segment being stepped and the pixels still owed by the block
   class pixel_tracker;
      localparam longint STEP     = longint'(1) << COORD_FRAC_BITS;
      localparam longint ERR_ONE  = longint'(1) << SLOPE_FRAC_BITS;
      localparam longint ERR_HALF = longint'(1) << (SLOPE_FRAC_BITS - 1);
      localparam longint ERR_HIGH = (longint'(1) << (SLOPE_FRAC_BITS + 1)) - 1;
      localparam longint ERR_LOW  = -ERR_HIGH - 1;

      logic [ZOOM_W-1:0]          zoom;
      logic signed [MARGIN_W-1:0] margin_x;
      logic signed [MARGIN_W-1:0] margin_y;
      logic [WIN_W-1:0]           window_width;
      logic [WIN_W-1:0]           window_height;
      logic [COLOR_W-1:0]         draw_color;
      logic [STRIDE_W-1:0]        row_stride;
      logic [BPP_W-1:0]           bits_per_pixel;

      longint     major_pos, minor_pos, major_end, error_term, slope;
      octant_type oct;
      bit         active;

      pixel_t pending_pixels[$];
      int     errors;
      int     pixels_checked;
      int     segments_ended;

      function new();
         zoom           = ZOOM_RST;
         margin_x       = '0;
         margin_y       = '0;
         window_width   = WIDTH_RST;
         window_height  = HEIGHT_RST;
         draw_color     = COLOR_RST;
         row_stride     = STRIDE_RST;
         bits_per_pixel = BPP_RST;
         major_pos      = 0;
         minor_pos      = 0;
         major_end      = 0;
         error_term     = 0;
         slope          = 0;
         oct            = OCT_SHALLOW_RISE;
         active         = 0;
         errors         = 0;
         pixels_checked = 0;
         segments_ended = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_ZOOM:     zoom           = value[ZOOM_W-1:0];
            CSR_MARGIN_X: margin_x       = value[MARGIN_W-1:0];
            CSR_MARGIN_Y: margin_y       = value[MARGIN_W-1:0];
            CSR_WIDTH:    window_width   = value[WIN_W-1:0];
            CSR_HEIGHT:   window_height  = value[WIN_W-1:0];
            CSR_COLOR:    draw_color     = value[COLOR_W-1:0];
            CSR_STRIDE:   row_stride     = value[STRIDE_W-1:0];
            CSR_BPP:      bits_per_pixel = value[BPP_W-1:0];
            default: ;
         endcase
      endfunction

      // zoom is Q8.8, so the product loses eight bits with floor rounding
      function longint scale_coord(logic signed [IN_W-1:0] c, logic signed [MARGIN_W-1:0] m);
         return ((longint'(c) * longint'(zoom)) >>> 8) + longint'(m) * STEP;
      endfunction

      function longint clamp_error(longint v);
         if (v > ERR_HIGH) return ERR_HIGH;
         if (v < ERR_LOW) return ERR_LOW;
         return v;
      endfunction

      function bit still_going();
         if (oct == OCT_STEEP_FALL) return major_pos >= major_end;
         return major_pos <= major_end;
      endfunction

      // returns 1 when the command does anything: a load, or a tick that owes a pixel
      function bit note_command(line_cmd_t cmd);
         longint x1, y1, x2, y2, num, den, x, y, e;
         bit     in_window;
         pixel_t px;
         if (cmd.opcode == OP_LOAD) begin
            x1  = scale_coord(cmd.start_x, margin_x);
            y1  = scale_coord(cmd.start_y, margin_y);
            x2  = scale_coord(cmd.end_x, margin_x);
            y2  = scale_coord(cmd.end_y, margin_y);
            oct = cmd.octant;
            case (oct)
               OCT_SHALLOW_RISE: begin
                  num = y2 - y1; den = x2 - x1;
                  major_pos = x1; minor_pos = y1; major_end = x2;
               end
               OCT_STEEP_RISE: begin
                  num = x2 - x1; den = y2 - y1;
                  major_pos = y1; minor_pos = x1; major_end = y2;
               end
               OCT_STEEP_FALL: begin
                  num = x2 - x1; den = y1 - y2;
                  major_pos = y1; minor_pos = x1; major_end = y2;
               end
               default: begin
                  num = y1 - y2; den = x2 - x1;
                  major_pos = x1; minor_pos = y1; major_end = x2;
               end
            endcase
            slope      = (den == 0) ? 0 : clamp_error((num * ERR_ONE) / den);
            error_term = 0;
            active     = still_going();
            return 1;
         end
         if (!active) return 0;
         if (oct == OCT_SHALLOW_RISE || oct == OCT_SHALLOW_FALL) begin
            x = major_pos; y = minor_pos;
         end else begin
            x = minor_pos; y = major_pos;
         end
         in_window = x >= 0 && y >= 0 && x <= longint'(window_width) * STEP &&
                     y <= longint'(window_height) * STEP;
         px = '0;
         px.write = in_window;
         if (in_window) begin
            px.offset = OFFSET_W'((y >>> COORD_FRAC_BITS) * longint'(row_stride) +
                                  (x >>> COORD_FRAC_BITS) * (longint'(bits_per_pixel) / 8));
            px.color  = draw_color;
         end
         e = clamp_error(error_term + slope);
         if (e >= ERR_HALF) begin
            minor_pos += (oct == OCT_SHALLOW_FALL) ? -STEP : STEP;
            e -= ERR_ONE;
         end
         error_term  = e;
         major_pos  += (oct == OCT_STEEP_FALL) ? -STEP : STEP;
         active      = still_going();
         px.finished = !active;
         pending_pixels.push_back(px);
         return 1;
      endfunction

      function void check_pixel(pixel_t got);
         pixel_t exp_px;
         if (pending_pixels.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: pixel transfer with none pending: write %0b offset %h color %h fin %0b",
                        $time, got.write, got.offset, got.color, got.finished);
            return;
         end
         exp_px = pending_pixels.pop_front();
         pixels_checked++;
         if (exp_px.finished) segments_ended++;
         if (got !== exp_px) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               if (got.write !== exp_px.write)
                  $display("%0t: pixel_write expected %0b actual %0b",
                           $time, exp_px.write, got.write);
               if (got.offset !== exp_px.offset)
                  $display("%0t: pixel_offset expected %h actual %h",
                           $time, exp_px.offset, got.offset);
               if (got.color !== exp_px.color)
                  $display("%0t: pixel_color expected %h actual %h",
                           $time, exp_px.color, got.color);
               if (got.finished !== exp_px.finished)
                  $display("%0t: finished expected %0b actual %0b",
                           $time, exp_px.finished, got.finished);
            end
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   olr_req_if req_bus();
   olr_rsp_if rsp_bus();

   octant_line_rasterizer_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pixel_tracker          tracker;
   logic [CSR_DATA_W-1:0] setting_word [8];
   bit                    sender_calm;
   bit                    receiver_calm;
   int                    commands_sent;
   int                    useful_commands;
   int                    settings_applied;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #6_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic logic signed [IN_W-1:0] clamp_map(longint v);
      if (v > MAP_HIGH) return IN_W'(MAP_HIGH);
      if (v < MAP_LOW) return IN_W'(MAP_LOW);
      return IN_W'(v);
   endfunction

   // map units that land near the wanted Q8 pixel position under the current zoom
   function automatic longint to_map(longint pix_q8);
      if (tracker.zoom == 0) return longint'(clamp_map(longint'($urandom_range(0, 8191)) - 4096));
      return longint'(clamp_map(pix_q8 * 256 / longint'(tracker.zoom)));
   endfunction

   task automatic send_command(line_cmd_t cmd);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.opcode  <= cmd.opcode;
      req_bus.octant  <= cmd.octant;
      req_bus.start_x <= cmd.start_x;
      req_bus.start_y <= cmd.start_y;
      req_bus.end_x   <= cmd.end_x;
      req_bus.end_y   <= cmd.end_y;
      do @(posedge clock); while (!req_bus.ready);
      if (tracker.note_command(cmd)) useful_commands++;
      commands_sent++;
      if (commands_sent % 48 == 0) sender_calm = ($urandom_range(0, 3) == 0);
   endtask

   task automatic send_load(octant_type o, logic signed [IN_W-1:0] sx,
                            logic signed [IN_W-1:0] sy, logic signed [IN_W-1:0] ex,
                            logic signed [IN_W-1:0] ey);
      line_cmd_t cmd;
      cmd.opcode  = OP_LOAD;
      cmd.octant  = o;
      cmd.start_x = sx;
      cmd.start_y = sy;
      cmd.end_x   = ex;
      cmd.end_y   = ey;
      send_command(cmd);
   endtask

   // coordinates of a tick are don't-care, so they carry noise
   task automatic send_ticks(int n);
      line_cmd_t cmd;
      repeat (n) begin
         cmd.opcode  = OP_TICK;
         cmd.octant  = octant_type'($urandom_range(0, 3));
         cmd.start_x = IN_W'($urandom);
         cmd.start_y = IN_W'($urandom);
         cmd.end_x   = IN_W'($urandom);
         cmd.end_y   = IN_W'($urandom);
         send_command(cmd);
      end
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (tracker.pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings();
      csr_index_type r;
      r = r.first();
      do begin
         csr_we    <= 1'b1;
         csr_index <= r;
         csr_wdata <= setting_word[r];
         tracker.set_register(r, setting_word[r]);
         @(posedge clock);
         r = r.next();
      end while (r != r.first());
      csr_we <= 1'b0;
      settings_applied++;
   endtask

   // short segment near the window, drawn in its own octant, usually ticked to the end
   task automatic send_segment();
      octant_type o;
      int         len, lean, tx, ty, n;
      longint     mx, my, dmaj, dmin, ex, ey;
      o    = octant_type'($urandom_range(0, 3));
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
      lean = $urandom_range(0, len);
      tx   = int'($urandom_range(0, int'(tracker.window_width) + 16)) - 8;
      ty   = int'($urandom_range(0, int'(tracker.window_height) + 16)) - 8;
      mx   = to_map((longint'(tx) - longint'(tracker.margin_x)) * 256 +
                    longint'($urandom_range(0, 255)));
      my   = to_map((longint'(ty) - longint'(tracker.margin_y)) * 256 +
                    longint'($urandom_range(0, 255)));
      if (tracker.zoom == 0) begin
         dmaj = longint'($urandom_range(0, 4096));
         dmin = longint'($urandom_range(0, 4096));
      end else begin
         dmaj = (longint'(len) * 65536 + longint'($urandom_range(0, 255))) /
                longint'(tracker.zoom);
         dmin = (longint'(lean) * 65536 + longint'($urandom_range(0, 255))) /
                longint'(tracker.zoom);
      end
      case (o)
         OCT_SHALLOW_RISE: begin ex = mx + dmaj; ey = my + dmin; end
         OCT_STEEP_RISE:   begin ex = mx + dmin; ey = my + dmaj; end
         OCT_STEEP_FALL:   begin ex = mx + dmin; ey = my - dmaj; end
         default:          begin ex = mx + dmaj; ey = my - dmin; end
      endcase
      send_load(o, clamp_map(mx), clamp_map(my), clamp_map(ex), clamp_map(ey));
      // now and then cut the segment short so the next load replaces it
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len) : len + 1 + $urandom_range(0, 2);
      send_ticks(n);
   endtask

   task automatic run_random_phase(int quota);
      int start_count, pick;
      start_count = commands_sent;
      while (commands_sent - start_count < quota) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            send_segment();
         end else if (pick < 88) begin
            send_load(octant_type'($urandom_range(0, 3)), IN_W'($urandom), IN_W'($urandom),
                      IN_W'($urandom), IN_W'($urandom));
            send_ticks($urandom_range(0, 6));
         end else if (pick < 98) begin
            send_ticks($urandom_range(1, 4));
         end else begin
            drain();
         end
      end
   endtask

   task automatic pick_settings(int phase);
      case (phase)
         2: begin
            setting_word[CSR_ZOOM]     = '0;
            setting_word[CSR_MARGIN_X] = CSR_DATA_W'(13'h1000);
            setting_word[CSR_MARGIN_Y] = CSR_DATA_W'(13'h1000);
            setting_word[CSR_WIDTH]    = '0;
            setting_word[CSR_HEIGHT]   = '0;
            setting_word[CSR_COLOR]    = '0;
            setting_word[CSR_STRIDE]   = '0;
            setting_word[CSR_BPP]      = 8;
         end
         5: begin
            setting_word[CSR_ZOOM]     = CSR_DATA_W'(16'hFFFF);
            setting_word[CSR_MARGIN_X] = CSR_DATA_W'(13'h0FFF);
            setting_word[CSR_MARGIN_Y] = CSR_DATA_W'(13'h0FFF);
            setting_word[CSR_WIDTH]    = CSR_DATA_W'(12'hFFF);
            setting_word[CSR_HEIGHT]   = CSR_DATA_W'(12'hFFF);
            setting_word[CSR_COLOR]    = 32'hFFFF_FFFF;
            setting_word[CSR_STRIDE]   = CSR_DATA_W'(16'hFFFF);
            setting_word[CSR_BPP]      = 32;
         end
         7: begin
            setting_word[CSR_ZOOM]     = CSR_DATA_W'(ZOOM_RST);
            setting_word[CSR_MARGIN_X] = '0;
            setting_word[CSR_MARGIN_Y] = '0;
            setting_word[CSR_WIDTH]    = CSR_DATA_W'(WIDTH_RST);
            setting_word[CSR_HEIGHT]   = CSR_DATA_W'(HEIGHT_RST);
            setting_word[CSR_COLOR]    = COLOR_RST;
            setting_word[CSR_STRIDE]   = CSR_DATA_W'(STRIDE_RST);
            setting_word[CSR_BPP]      = CSR_DATA_W'(BPP_RST);
         end
         default: begin
            setting_word[CSR_ZOOM]     = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535)
                                                                     : $urandom_range(32, 1024);
            setting_word[CSR_MARGIN_X] = CSR_DATA_W'(13'($urandom_range(0, 128) - 64));
            setting_word[CSR_MARGIN_Y] = ($urandom_range(0, 3) == 0) ? CSR_DATA_W'(13'($urandom))
                                       : CSR_DATA_W'(13'($urandom_range(0, 128) - 64));
            setting_word[CSR_WIDTH]    = $urandom_range(0, 4095);
            setting_word[CSR_HEIGHT]   = $urandom_range(0, 4095);
            setting_word[CSR_COLOR]    = $urandom;
            setting_word[CSR_STRIDE]   = $urandom_range(0, 65535);
            setting_word[CSR_BPP]      = $urandom_range(8, 32);
         end
      endcase
   endtask

   initial begin
      tracker          = new();
      commands_sent    = 0;
      useful_commands  = 0;
      settings_applied = 0;
      sender_calm      = 1'b0;
      receiver_calm    = 1'b0;
      reset           <= 1'b1;
      csr_we          <= 1'b0;
      csr_index       <= CSR_ZOOM;
      csr_wdata       <= '0;
      req_bus.valid   <= 1'b0;
      req_bus.opcode  <= OP_LOAD;
      req_bus.octant  <= OCT_SHALLOW_RISE;
      req_bus.start_x <= '0;
      req_bus.start_y <= '0;
      req_bus.end_x   <= '0;
      req_bus.end_y   <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part under the reset settings
      send_ticks(1);
      send_load(OCT_SHALLOW_RISE, 0, 0, 1280, 512);
      send_ticks(7);
      send_load(OCT_STEEP_RISE, 100, 50, 612, 818);
      send_ticks(4);
      send_load(OCT_STEEP_FALL, 2000, 1024, 2600, 0);
      send_ticks(2);
      // replaces the steep falling segment while it is still running
      send_load(OCT_SHALLOW_FALL, -512, 512, 512, -300);
      send_ticks(3);
      // zero denominator, a single point
      send_load(OCT_SHALLOW_RISE, 300, 300, 300, 900);
      send_ticks(1);
      // major end before start, nothing to draw
      send_load(OCT_STEEP_RISE, 0, 900, 0, 100);
      send_ticks(1);
      // slope and error saturate
      send_load(OCT_SHALLOW_RISE, 0, 0, 256, 1048575);
      send_ticks(3);
      send_load(OCT_SHALLOW_FALL, -1048576, 1048575, 1048575, -1048576);
      send_ticks(1);
      drain();

      for (int phase = 0; phase < PHASES; phase++) begin
         pick_settings(phase);
         apply_settings();
         run_random_phase(RANDOM_ITEMS / PHASES);
         drain();
      end

      $display("ran %0d commands (%0d loads or live ticks) over %0d register settings",
               commands_sent, useful_commands, settings_applied);
      $display("compared %0d pixels, %0d segments stepped to their last point",
               tracker.pixels_checked, tracker.segments_ended);
      if (tracker.errors == 0 && tracker.pending_pixels.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin : pixel_sink
      int     stall;
      int     taken;
      pixel_t got;
      taken = 0;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = receiver_calm ? 0 : $urandom_range(0, 8);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         got.write    = rsp_bus.pixel_write;
         got.offset   = rsp_bus.pixel_offset;
         got.color    = rsp_bus.pixel_color;
         got.finished = rsp_bus.finished;
         tracker.check_pixel(got);
         taken++;
         if (taken % 40 == 0) receiver_calm = ($urandom_range(0, 3) == 0);
      end
   end

endmodule
